// ----- hdl/gcfd_pkg.sv -----
// Package: shared types and constants of the gimbal CAN frame decoder.
package gcfd_pkg;

	localparam int ACC_BITS  = 40;
	localparam int TURN_BITS = 16;
	localparam int OFF_BITS  = TURN_BITS + 16;
	localparam int SUM_BITS  = ((OFF_BITS > 33) ? OFF_BITS : 33) + 1;

	localparam logic [10:0] ID_YAW     = 11'h401;
	localparam logic [10:0] ID_CHASSIS = 11'h501;
	localparam logic [10:0] ID_STICK   = 11'h402;

	localparam logic [7:0] SHOOT_FIRE_A = 8'd1;
	localparam logic [7:0] SHOOT_IDLE   = 8'd2;
	localparam logic [7:0] SHOOT_FIRE_B = 8'd3;

	localparam logic [1:0] CFG_STICK_CENTER = 2'd0;
	localparam logic [1:0] CFG_FIRE_WIDTH   = 2'd1;
	localparam logic [1:0] CFG_IDLE_WIDTH   = 2'd2;

	localparam logic [15:0] STICK_CENTER_RST = 16'd1024;
	localparam logic [10:0] FIRE_WIDTH_RST   = 11'd1750;
	localparam logic [10:0] IDLE_WIDTH_RST   = 11'd1000;

	typedef struct packed {
		logic [10:0] id;
		logic [7:0]  b0;
		logic [7:0]  b1;
		logic [7:0]  b2;
		logic [7:0]  b3;
		logic [7:0]  b5;
		logic [7:0]  b6;
	} frame_t;

	typedef struct packed {
		logic [15:0] stick_center;
		logic [10:0] fire_width;
		logic [10:0] idle_width;
	} cfg_t;

endpackage

// ----- hdl/gcfd_cfg.sv -----
// Configuration register file of the gimbal CAN frame decoder.
module gcfd_cfg
	import gcfd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output cfg_t        cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.stick_center <= STICK_CENTER_RST;
			cfg_q.fire_width   <= FIRE_WIDTH_RST;
			cfg_q.idle_width   <= IDLE_WIDTH_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_STICK_CENTER: cfg_q.stick_center <= cfg_data;
				CFG_FIRE_WIDTH:   cfg_q.fire_width   <= cfg_data[10:0];
				CFG_IDLE_WIDTH:   cfg_q.idle_width   <= cfg_data[10:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- hdl/gcfd_core.sv -----
// Decode state and per-frame update logic of the gimbal CAN frame decoder.
module gcfd_core
	import gcfd_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       load,
	input  frame_t                     frame,
	input  cfg_t                       cfg,
	output logic signed [32:0]         yaw_continuous,
	output logic signed [32:0]         chassis_angle,
	output logic signed [ACC_BITS-1:0] yaw_target,
	output logic signed [ACC_BITS-1:0] pitch_target,
	output logic [10:0]                pwm_width,
	output logic [7:0]                 mode_value,
	output logic                       gyro_seen
);

	localparam logic signed [TURN_BITS-1:0] TURN_MAX = {1'b0, {(TURN_BITS-1){1'b1}}};
	localparam logic signed [TURN_BITS-1:0] TURN_MIN = {1'b1, {(TURN_BITS-1){1'b0}}};
	localparam logic signed [OFF_BITS-1:0]  FULL_TURN = OFF_BITS'(36000);
	localparam logic signed [33:0]          HALF_TURN = 34'sd18000;

	function automatic logic signed [ACC_BITS-1:0] acc_sat(
		input logic signed [ACC_BITS-1:0] acc,
		input logic signed [18:0]         inc
	);
		logic signed [ACC_BITS:0] sum;
		sum = {acc[ACC_BITS-1], acc} + {{(ACC_BITS+1-19){inc[18]}}, inc};
		if (sum[ACC_BITS] != sum[ACC_BITS-1])
			acc_sat = {sum[ACC_BITS], {(ACC_BITS-1){~sum[ACC_BITS]}}};
		else
			acc_sat = sum[ACC_BITS-1:0];
	endfunction

	logic signed [32:0]          last_yaw_q;
	logic signed [TURN_BITS-1:0] turn_q;
	logic signed [OFF_BITS-1:0]  offset_q;
	logic signed [32:0]          chassis_q;
	logic signed [ACC_BITS-1:0]  yaw_acc_q;
	logic signed [ACC_BITS-1:0]  pitch_acc_q;
	logic [10:0]                 pwm_q;
	logic [7:0]                  mode_q;
	logic                        gyro_q;
	logic signed [32:0]          yaw_cont_q;

	logic [31:0]                 raw;
	logic signed [32:0]          angle;
	logic signed [33:0]          diff;
	logic                        turn_up;
	logic                        turn_dn;
	logic signed [32:0]          last_yaw_d;
	logic signed [TURN_BITS-1:0] turn_d;
	logic signed [OFF_BITS-1:0]  offset_d;
	logic signed [SUM_BITS-1:0]  yaw_sum;
	logic signed [32:0]          yaw_cont_d;
	logic signed [16:0]          ys;
	logic signed [16:0]          ps;
	logic signed [18:0]          yaw_inc;
	logic signed [18:0]          pitch_inc;
	logic                        is_yaw;

	assign is_yaw = (frame.id == ID_YAW);
	assign raw    = {frame.b0, frame.b1, frame.b2, frame.b3};
	assign angle  = 33'sd0 - $signed({raw[31], raw});
	assign diff   = {angle[32], angle} - {last_yaw_q[32], last_yaw_q};
	assign turn_up = is_yaw && (diff > HALF_TURN) && (turn_q != TURN_MAX);
	assign turn_dn = is_yaw && (diff < -HALF_TURN) && (turn_q != TURN_MIN);

	always_comb begin
		last_yaw_d = is_yaw ? angle : last_yaw_q;
		turn_d     = turn_q;
		offset_d   = offset_q;
		if (turn_up) begin
			turn_d   = turn_q + TURN_BITS'(1);
			offset_d = offset_q + FULL_TURN;
		end else if (turn_dn) begin
			turn_d   = turn_q - TURN_BITS'(1);
			offset_d = offset_q - FULL_TURN;
		end
		yaw_sum = {{(SUM_BITS-33){last_yaw_d[32]}}, last_yaw_d}
			+ {{(SUM_BITS-OFF_BITS){offset_d[OFF_BITS-1]}}, offset_d};
		if (yaw_sum[SUM_BITS-1:32] != {(SUM_BITS-32){yaw_sum[SUM_BITS-1]}})
			yaw_cont_d = {yaw_sum[SUM_BITS-1], {32{~yaw_sum[SUM_BITS-1]}}};
		else
			yaw_cont_d = yaw_sum[32:0];
	end

	assign ys = $signed({1'b0, frame.b0, frame.b1}) - $signed({1'b0, cfg.stick_center});
	assign ps = $signed({1'b0, frame.b2, frame.b3}) - $signed({1'b0, cfg.stick_center});
	assign yaw_inc   = {ys[16], ys[16], ys} + {ys[16], ys, 1'b0};
	assign pitch_inc = 19'sd0 - ({ps[16], ps[16], ps} + {ps[16], ps, 1'b0});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_yaw_q  <= '0;
			turn_q      <= '0;
			offset_q    <= '0;
			chassis_q   <= '0;
			yaw_acc_q   <= '0;
			pitch_acc_q <= '0;
			pwm_q       <= IDLE_WIDTH_RST;
			mode_q      <= '0;
			gyro_q      <= 1'b0;
			yaw_cont_q  <= '0;
		end else if (load) begin
			last_yaw_q <= last_yaw_d;
			turn_q     <= turn_d;
			offset_q   <= offset_d;
			yaw_cont_q <= yaw_cont_d;
			if (is_yaw)
				gyro_q <= 1'b1;
			if (frame.id == ID_CHASSIS)
				chassis_q <= angle;
			if (frame.id == ID_STICK) begin
				yaw_acc_q   <= acc_sat(yaw_acc_q, yaw_inc);
				pitch_acc_q <= acc_sat(pitch_acc_q, pitch_inc);
				mode_q      <= frame.b6;
				// any other shooting code keeps the current width
				if (frame.b5 == SHOOT_FIRE_A || frame.b5 == SHOOT_FIRE_B)
					pwm_q <= cfg.fire_width;
				else if (frame.b5 == SHOOT_IDLE)
					pwm_q <= cfg.idle_width;
			end
		end
	end

	assign yaw_continuous = yaw_cont_q;
	assign chassis_angle  = chassis_q;
	assign yaw_target     = yaw_acc_q;
	assign pitch_target   = pitch_acc_q;
	assign pwm_width      = pwm_q;
	assign mode_value     = mode_q;
	assign gyro_seen      = gyro_q;

endmodule

// ----- hdl/gimbal_can_frame_decoder.sv -----
// Top level of the gimbal CAN frame decoder: input stage, handshake and result register.
//
// Input channel: in_valid/in_ready with frame_id and payload bytes; one frame
// is taken per transfer. Output channel: out_valid/out_ready; every frame
// yields exactly one result carrying all current decoded values.
// Configuration: cfg_we writes cfg_data to register cfg_index (0 stick
// center, 1 fire width, 2 idle width) in the same cycle; other indexes are
// ignored. Writes are meant for idle periods only.
// Path: a frame accepted from the input channel is held in the input stage
// and updates the state and the result register when that register can
// advance, where out_valid rises.
// Throughput: one frame per cycle while no result waits on out_ready; the
// state update between the input stage and the result register is combinational.
// Stall: while a result waits on out_ready the input stage still takes one
// more frame; further frames wait until the result transfers.
// Reset: arst_n clears both stages, the turn count, angles and targets,
// sets the PWM width to the idle reset width and the registers to defaults.
module gimbal_can_frame_decoder
	import gcfd_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [10:0]                frame_id,
	input  logic [7:0]                 byte0,
	input  logic [7:0]                 byte1,
	input  logic [7:0]                 byte2,
	input  logic [7:0]                 byte3,
	input  logic [7:0]                 byte5,
	input  logic [7:0]                 byte6,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic signed [32:0]         yaw_continuous,
	output logic signed [32:0]         chassis_angle,
	output logic signed [ACC_BITS-1:0] yaw_target,
	output logic signed [ACC_BITS-1:0] pitch_target,
	output logic [10:0]                pwm_width,
	output logic [7:0]                 mode_value,
	output logic                       gyro_seen,
	input  logic                       cfg_we,
	input  logic [1:0]                 cfg_index,
	input  logic [15:0]                cfg_data
);

	cfg_t   cfg;
	frame_t frame_s1;
	logic   valid_s1;
	logic   out_valid_q;
	logic   adv;
	logic   load;

	assign adv      = !out_valid_q || out_ready;
	assign in_ready = !valid_s1 || adv;
	assign load     = adv && valid_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ready)
				valid_s1 <= in_valid;
			if (adv)
				out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			frame_s1.id <= frame_id;
			frame_s1.b0 <= byte0;
			frame_s1.b1 <= byte1;
			frame_s1.b2 <= byte2;
			frame_s1.b3 <= byte3;
			frame_s1.b5 <= byte5;
			frame_s1.b6 <= byte6;
		end
	end

	gcfd_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	gcfd_core u_core (
		.clk            (clk),
		.arst_n         (arst_n),
		.load           (load),
		.frame          (frame_s1),
		.cfg            (cfg),
		.yaw_continuous (yaw_continuous),
		.chassis_angle  (chassis_angle),
		.yaw_target     (yaw_target),
		.pitch_target   (pitch_target),
		.pwm_width      (pwm_width),
		.mode_value     (mode_value),
		.gyro_seen      (gyro_seen)
	);

	assign out_valid = out_valid_q;

endmodule

// ----- hdl/gcfd_checker.sv -----
// Port-level assertion checker for the gimbal CAN frame decoder, with its bind.
module gcfd_checker
	import gcfd_pkg::*;
(
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_ready,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic signed [32:0]         yaw_continuous,
	input logic signed [ACC_BITS-1:0] yaw_target,
	input logic [7:0]                 mode_value,
	input logic                       gyro_seen
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(yaw_continuous)
			&& $stable(yaw_target))
		else $error("result changed while stalled");

	a_gyro_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		gyro_seen |=> gyro_seen)
		else $error("gyro_seen dropped");

	a_mode_with_result: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(mode_value) |-> out_valid)
		else $error("mode changed without a new result");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output");

endmodule

bind gimbal_can_frame_decoder gcfd_checker u_gcfd_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_ready       (in_ready),
	.out_valid      (out_valid),
	.out_ready      (out_ready),
	.yaw_continuous (yaw_continuous),
	.yaw_target     (yaw_target),
	.mode_value     (mode_value),
	.gyro_seen      (gyro_seen)
);
